@@ design/pmm_pkg.sv @@
// shared types and codes for the paged memory map store/load unit
// no dependencies
package pmm_pkg;

  localparam int unsigned PAGE_W = 4;
  localparam int unsigned PA_W   = 7;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_STORE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_FLAG   = 3'd1,
    ST_MAPPED     = 3'd2,
    ST_NO_FRAME   = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_UNMAPPED   = 3'd5,
    ST_READ_ONLY  = 3'd6,
    ST_ZERO_READ  = 3'd7
  } status_e;

  typedef struct packed {
    logic    load;
    logic    clear_step;
    logic    div_step;
    logic    scan;
    logic    map_write;
    logic    pa_init;
    logic    wrap_step;
    logic    mem_write;
    logic    mem_read;
    logic    take_read;
    logic    set_status;
    status_e code;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic clear_done;
    logic div_done;
    logic scan_done;
    logic bad_flag;
    logic found;
    logic writable;
    logic any_free;
    logic found_zero;
    logic wrap_done;
  } stat_t;

endpackage

@@ design/paged_memory_map_store_load_unit.sv @@
// Paged memory map store/load unit. After reset the unit clears its MEMORY_BYTES-byte memory,
// one byte per cycle, and holds busy high while it does so. A command is taken when start is
// high and busy is low; busy stays high until the result has been shown. The next command can
// be taken in the cycle after done. A command first splits the virtual address, one page split
// step per page plus a check, where page is virtual_address / PAGE_BYTES; then it scans the
// page-table bytes (PAGE_BYTES of them, fewer if the memory is smaller) through the single
// memory port with one byte read per cycle, then makes the decision. A store or load wraps a
// translated address at or past MEMORY_BYTES by subtracting MEMORY_BYTES step by step, then
// accesses the data on the same port. The result is on status, physical_address,
// read_data and frame for exactly one cycle while done is high and has to be captured then; the
// unit never waits for the receiver. Operation code 3 is taken but gives no result.
// depends on pmm_pkg, pmm_ctrl, pmm_datapath
module paged_memory_map_store_load_unit #(
  parameter int unsigned PAGE_BYTES   = 16,
  parameter int unsigned FRAME_COUNT  = 4,
  parameter int unsigned MEMORY_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [1:0] process_id,
  input  logic [5:0] virtual_address,
  input  logic [7:0] value,
  output logic       done,
  output logic [2:0] status,
  output logic [5:0] physical_address,
  output logic [7:0] read_data,
  output logic [1:0] frame
);

  pmm_pkg::cmd_t  cmd;
  pmm_pkg::stat_t stat;

  pmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .stat      (stat)
  );

  pmm_datapath #(
    .PAGE_BYTES   (PAGE_BYTES),
    .FRAME_COUNT  (FRAME_COUNT),
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .process_id       (process_id),
    .virtual_address  (virtual_address),
    .value            (value),
    .status           (status),
    .physical_address (physical_address),
    .read_data        (read_data),
    .frame            (frame)
  );

endmodule

@@ design/pmm_datapath.sv @@
// datapath: byte memory, page table scan, frame allocation, address translation
// depends on pmm_pkg
module pmm_datapath #(
  parameter int unsigned PAGE_BYTES   = 16,
  parameter int unsigned FRAME_COUNT  = 4,
  parameter int unsigned MEMORY_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  pmm_pkg::cmd_t       cmd,
  output pmm_pkg::stat_t      stat,
  input  logic [1:0]          operation,
  input  logic [1:0]          process_id,
  input  logic [5:0]          virtual_address,
  input  logic [7:0]          value,
  output logic [2:0]          status,
  output logic [5:0]          physical_address,
  output logic [7:0]          read_data,
  output logic [1:0]          frame
);

  localparam int unsigned AW     = $clog2(MEMORY_BYTES);
  localparam int unsigned SCAN_N = (PAGE_BYTES < MEMORY_BYTES) ? PAGE_BYTES : MEMORY_BYTES;

  logic [7:0] mem [MEMORY_BYTES];
  logic [7:0] rd_q;

  pmm_pkg::op_e     op;
  logic [1:0]       pid;
  logic [7:0]       val;
  logic [5:0]       off;
  logic [pmm_pkg::PAGE_W-1:0] page;
  logic [AW-1:0]    clr_idx;
  logic [AW-1:0]    scan_idx;
  logic             scan_run;
  logic [AW-1:0]    chk_idx;
  logic             chk_valid;
  logic             found;
  logic [7:0]       entry;
  logic             found_zero;
  logic [AW-1:0]    zero_idx;
  logic [FRAME_COUNT-1:0] free_flags;
  logic [pmm_pkg::PA_W-1:0] pa;
  pmm_pkg::status_e res_status;
  logic [5:0]       res_pa;
  logic [7:0]       res_rd;
  logic [1:0]       res_frame;

  logic             any_free;
  logic [1:0]       free_frame;
  logic             hit;
  logic [AW-1:0]    addr;
  logic [7:0]       wdata;
  logic             we;
  logic [7:0]       new_entry;

  always_comb begin
    any_free   = 1'b0;
    free_frame = 2'd0;
    for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
      if (free_flags[f]) begin
        any_free   = 1'b1;
        free_frame = 2'(f);
      end
    end
  end

  assign hit = (rd_q != 8'd0) && (rd_q[2:1] == pid) &&
               ({{(pmm_pkg::PAGE_W-2){1'b0}}, rd_q[4:3]} == page);

  assign new_entry = {val[0], free_frame, page[1:0], pid, 1'b1};

  always_comb begin
    we    = cmd.clear_step | cmd.map_write | cmd.mem_write;
    wdata = 8'd0;
    addr  = scan_idx;
    if (cmd.clear_step) begin
      addr = clr_idx;
    end else if (cmd.map_write) begin
      addr  = zero_idx;
      wdata = new_entry;
    end else if (cmd.mem_write || cmd.mem_read) begin
      addr  = pa[AW-1:0];
      wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      free_flags <= {{(FRAME_COUNT-1){1'b1}}, 1'b0};
      scan_run   <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.load) begin
        op         <= pmm_pkg::op_e'(operation);
        pid        <= process_id;
        val        <= value;
        off        <= virtual_address;
        page       <= '0;
        scan_idx   <= '0;
        scan_run   <= 1'b1;
        chk_valid  <= 1'b0;
        found      <= 1'b0;
        found_zero <= 1'b0;
        pa         <= '0;
        res_status <= pmm_pkg::ST_OK;
        res_pa     <= '0;
        res_rd     <= '0;
        res_frame  <= '0;
      end
      if (cmd.div_step) begin
        off  <= off - 6'(PAGE_BYTES);
        page <= page + 1'b1;
      end
      if (cmd.scan) begin
        chk_valid <= scan_run;
        chk_idx   <= scan_idx;
        if (scan_run) begin
          if (scan_idx == AW'(SCAN_N - 1)) begin
            scan_run <= 1'b0;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        if (chk_valid) begin
          if (hit && !found) begin
            found <= 1'b1;
            entry <= rd_q;
          end
          if (rd_q == 8'd0 && !found_zero) begin
            found_zero <= 1'b1;
            zero_idx   <= chk_idx;
          end
        end
      end
      if (cmd.map_write) begin
        free_flags[free_frame] <= 1'b0;
        res_frame              <= free_frame;
      end
      if (cmd.pa_init) begin
        pa        <= pmm_pkg::PA_W'(entry[6:5] * PAGE_BYTES) + pmm_pkg::PA_W'(off);
        res_frame <= entry[6:5];
      end
      if (cmd.wrap_step) begin
        pa <= pa - pmm_pkg::PA_W'(MEMORY_BYTES);
      end
      if (cmd.mem_write) begin
        res_pa <= pa[5:0];
      end
      if (cmd.set_status) begin
        res_status <= cmd.code;
      end
      if (cmd.take_read) begin
        res_rd     <= rd_q;
        res_pa     <= pa[5:0];
        res_status <= (rd_q == 8'd0) ? pmm_pkg::ST_ZERO_READ : pmm_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    stat.op         = op;
    stat.clear_done = (clr_idx == AW'(MEMORY_BYTES - 1));
    stat.div_done   = (off < 6'(PAGE_BYTES));
    stat.scan_done  = chk_valid && (chk_idx == AW'(SCAN_N - 1));
    stat.bad_flag   = (val > 8'd1);
    stat.found      = found;
    stat.writable   = entry[7];
    stat.any_free   = any_free;
    stat.found_zero = found_zero;
    stat.wrap_done  = (pa < pmm_pkg::PA_W'(MEMORY_BYTES));
  end

  assign status           = res_status;
  assign physical_address = res_pa;
  assign read_data        = res_rd;
  assign frame            = res_frame;

endmodule

@@ design/pmm_ctrl.sv @@
// controller state machine: sequences clear, split, scan, decide, access and result
// depends on pmm_pkg
module pmm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     operation,
  output logic           busy,
  output logic           done,
  output pmm_pkg::cmd_t  cmd,
  input  pmm_pkg::stat_t stat
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_WRAP   = 9'b000100000,
    S_READ   = 9'b001000000,
    S_TAKE   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = pmm_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (pmm_pkg::op_e'(operation) != pmm_pkg::OP_NONE) begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_SCAN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        if (stat.op == pmm_pkg::OP_MAP) begin
          cmd.set_status = 1'b1;
          if (stat.bad_flag) begin
            cmd.code = pmm_pkg::ST_BAD_FLAG;
          end else if (stat.found) begin
            cmd.code = pmm_pkg::ST_MAPPED;
          end else if (!stat.any_free) begin
            cmd.code = pmm_pkg::ST_NO_FRAME;
          end else if (!stat.found_zero) begin
            cmd.code = pmm_pkg::ST_TABLE_FULL;
          end else begin
            cmd.map_write = 1'b1;
          end
        end else if (!stat.found) begin
          cmd.set_status = 1'b1;
          cmd.code       = pmm_pkg::ST_UNMAPPED;
        end else begin
          cmd.pa_init = 1'b1;
          state_next  = S_WRAP;
        end
      end
      S_WRAP: begin
        if (!stat.wrap_done) begin
          cmd.wrap_step = 1'b1;
        end else if (stat.op == pmm_pkg::OP_STORE) begin
          state_next = S_DONE;
          if (!stat.writable) begin
            cmd.set_status = 1'b1;
            cmd.code       = pmm_pkg::ST_READ_ONLY;
          end else begin
            cmd.mem_write = 1'b1;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_TAKE;
      end
      S_TAKE: begin
        cmd.take_read = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for paged_memory_map_store_load_unit: a directed table,
// then random map/store/load beats checked against an in-bench page table predictor
// depends on pmm_pkg and paged_memory_map_store_load_unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pmm_pkg::*;

  localparam int PAGE_SIZE = 16;
  localparam int FRAMES = 4;
  localparam int MEM_SIZE = 64;
  localparam int RANDOM_BEATS = 1700;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_e    st;
    logic [5:0] pa;
    logic [7:0] rd;
    logic [1:0] fr;
  } xlate_t;

  typedef struct {
    op_e        op;
    logic [1:0] pid;
    logic [5:0] va;
    logic [7:0] val;
    bit         typed;
    xlate_t     reply;
  } script_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] operation;
  logic [1:0] process_id;
  logic [5:0] virtual_address;
  logic [7:0] value;
  logic       done;
  logic [2:0] status;
  logic [5:0] physical_address;
  logic [7:0] read_data;
  logic [1:0] frame;

  logic [7:0] phys_mem [MEM_SIZE];
  logic       frame_free [FRAMES];
  xlate_t     replies_due [$];
  int         mismatches = 0;
  int         cycles = 0;

  script_row_t opening_script [22] = '{
    '{OP_LOAD,  2'd0, 6'd0,  8'd0,   1'b1, '{ST_UNMAPPED,   6'd0,  8'd0, 2'd0}},
    '{OP_STORE, 2'd3, 6'd63, 8'd255, 1'b1, '{ST_UNMAPPED,   6'd0,  8'd0, 2'd0}},
    '{OP_MAP,   2'd0, 6'd0,  8'd2,   1'b1, '{ST_BAD_FLAG,   6'd0,  8'd0, 2'd0}},
    '{OP_MAP,   2'd0, 6'd0,  8'd255, 1'b1, '{ST_BAD_FLAG,   6'd0,  8'd0, 2'd0}},
    '{OP_MAP,   2'd0, 6'd0,  8'd1,   1'b1, '{ST_OK,         6'd0,  8'd0, 2'd1}},
    '{OP_MAP,   2'd0, 6'd5,  8'd1,   1'b1, '{ST_MAPPED,     6'd0,  8'd0, 2'd0}},
    '{OP_LOAD,  2'd0, 6'd3,  8'd0,   1'b1, '{ST_ZERO_READ,  6'd19, 8'd0, 2'd1}},
    '{OP_STORE, 2'd0, 6'd15, 8'd255, 1'b0, '{ST_OK,         6'd0,  8'd0, 2'd0}},
    '{OP_LOAD,  2'd0, 6'd15, 8'd0,   1'b0, '{ST_OK,         6'd0,  8'd0, 2'd0}},
    '{OP_LOAD,  2'd0, 6'd16, 8'd0,   1'b1, '{ST_UNMAPPED,   6'd0,  8'd0, 2'd0}},
    '{OP_MAP,   2'd3, 6'd63, 8'd0,   1'b1, '{ST_OK,         6'd0,  8'd0, 2'd2}},
    '{OP_STORE, 2'd3, 6'd48, 8'd170, 1'b1, '{ST_READ_ONLY,  6'd0,  8'd0, 2'd2}},
    '{OP_LOAD,  2'd3, 6'd48, 8'd0,   1'b1, '{ST_ZERO_READ,  6'd32, 8'd0, 2'd2}},
    '{OP_NONE,  2'd1, 6'd20, 8'd7,   1'b0, '{ST_OK,         6'd0,  8'd0, 2'd0}},
    '{OP_MAP,   2'd1, 6'd16, 8'd1,   1'b1, '{ST_OK,         6'd0,  8'd0, 2'd3}},
    '{OP_MAP,   2'd1, 6'd16, 8'd0,   1'b1, '{ST_MAPPED,     6'd0,  8'd0, 2'd0}},
    '{OP_MAP,   2'd2, 6'd32, 8'd1,   1'b1, '{ST_NO_FRAME,   6'd0,  8'd0, 2'd0}},
    '{OP_LOAD,  2'd2, 6'd40, 8'd0,   1'b1, '{ST_UNMAPPED,   6'd0,  8'd0, 2'd0}},
    '{OP_STORE, 2'd1, 6'd31, 8'd1,   1'b0, '{ST_OK,         6'd0,  8'd0, 2'd0}},
    '{OP_LOAD,  2'd1, 6'd31, 8'd0,   1'b0, '{ST_OK,         6'd0,  8'd0, 2'd0}},
    '{OP_STORE, 2'd1, 6'd16, 8'd128, 1'b0, '{ST_OK,         6'd0,  8'd0, 2'd0}},
    '{OP_LOAD,  2'd1, 6'd16, 8'd0,   1'b0, '{ST_OK,         6'd0,  8'd0, 2'd0}}
  };

  paged_memory_map_store_load_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .process_id       (process_id),
    .virtual_address  (virtual_address),
    .value            (value),
    .done             (done),
    .status           (status),
    .physical_address (physical_address),
    .read_data        (read_data),
    .frame            (frame)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int find_slot(logic [1:0] pid, int page);
    for (int i = 0; i < PAGE_SIZE && i < MEM_SIZE; i++) begin
      if (phys_mem[i] != 8'd0 && phys_mem[i][2:1] == pid && int'(phys_mem[i][4:3]) == page)
        return i;
    end
    return -1;
  endfunction

  // page table predictor: updates its own memory copy, returns 0 when no result is due
  function automatic bit translate_access(op_e op, logic [1:0] pid, logic [5:0] va,
                                          logic [7:0] val, output xlate_t r);
    int page;
    int offset;
    int f;
    int slot;
    int pa;
    logic [7:0] e;
    page = int'(va) / PAGE_SIZE;
    offset = int'(va) % PAGE_SIZE;
    r = '{ST_OK, 6'd0, 8'd0, 2'd0};
    if (op == OP_NONE)
      return 1'b0;
    if (op == OP_MAP) begin
      if (val > 8'd1) begin
        r.st = ST_BAD_FLAG;
      end else if (find_slot(pid, page) >= 0) begin
        r.st = ST_MAPPED;
      end else begin
        f = 0;
        while (f < FRAMES && !frame_free[f])
          f++;
        if (f == FRAMES) begin
          r.st = ST_NO_FRAME;
        end else begin
          slot = -1;
          for (int i = 0; i < PAGE_SIZE && i < MEM_SIZE; i++)
            if (slot < 0 && phys_mem[i] == 8'd0)
              slot = i;
          if (slot < 0) begin
            r.st = ST_TABLE_FULL;
          end else begin
            phys_mem[slot] = {val[0], 2'(f), 2'(page), pid, 1'b1};
            frame_free[f] = 1'b0;
            r.fr = 2'(f);
          end
        end
      end
    end else begin
      slot = find_slot(pid, page);
      if (slot < 0) begin
        r.st = ST_UNMAPPED;
      end else begin
        e = phys_mem[slot];
        pa = (int'(e[6:5]) * PAGE_SIZE + offset) % MEM_SIZE;
        r.fr = e[6:5];
        if (op == OP_STORE) begin
          if (!e[7]) begin
            r.st = ST_READ_ONLY;
          end else begin
            phys_mem[pa] = val;
            r.pa = 6'(pa);
          end
        end else begin
          r.pa = 6'(pa);
          r.rd = phys_mem[pa];
          if (r.rd == 8'd0)
            r.st = ST_ZERO_READ;
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic issue_beat(op_e op, logic [1:0] pid, logic [5:0] va, logic [7:0] val,
                            bit typed, xlate_t typed_reply);
    xlate_t predicted;
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    process_id <= pid;
    virtual_address <= va;
    value <= val;
    do
      @(posedge clk);
    while (busy !== 1'b0);
    if (translate_access(op, pid, va, val, predicted))
      replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (replies_due.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin : check_replies
    xlate_t want;
    if (!rst && done === 1'b1) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("unexpected result, status", status, 0);
      end else begin
        want = replies_due.pop_front();
        if (status !== want.st)
          flag_mismatch("status", status, want.st);
        if (physical_address !== want.pa)
          flag_mismatch("physical_address", physical_address, want.pa);
        if (read_data !== want.rd)
          flag_mismatch("read_data", read_data, want.rd);
        if (frame !== want.fr)
          flag_mismatch("frame", frame, want.fr);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int idle_pct [4];
    int phase;
    int beats;
    int slots [$];
    logic [7:0] e;
    op_e op;
    logic [1:0] pid;
    logic [5:0] va;
    logic [7:0] val;
    idle_pct = '{0, 48, 0, 23};
    rst = 1'b1;
    start = 1'b0;
    operation = OP_MAP;
    process_id = 2'd0;
    virtual_address = 6'd0;
    value = 8'd0;
    foreach (phys_mem[i])
      phys_mem[i] = 8'd0;
    foreach (frame_free[f])
      frame_free[f] = (f != 0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_script[i])
      issue_beat(opening_script[i].op, opening_script[i].pid, opening_script[i].va,
                 opening_script[i].val, opening_script[i].typed, opening_script[i].reply);

    beats = 0;
    phase = -1;
    while (beats < RANDOM_BEATS) begin
      if (beats / (RANDOM_BEATS / 4) != phase) begin
        phase = beats / (RANDOM_BEATS / 4);
        drain_replies();
      end
      if ($urandom_range(99) < 75) begin
        // well-formed access to a page that is in the table
        slots.delete();
        for (int i = 0; i < PAGE_SIZE; i++)
          if (phys_mem[i] != 8'd0)
            slots.push_back(i);
        e = phys_mem[slots[$urandom_range(slots.size() - 1)]];
        op = $urandom_range(1) ? OP_STORE : OP_LOAD;
        pid = e[2:1];
        va = {e[4:3], 4'($urandom_range(15))};
        val = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
      end else begin
        op = op_e'($urandom_range(3));
        pid = 2'($urandom_range(3));
        va = 6'($urandom_range(63));
        val = ($urandom_range(3) == 0) ? 8'($urandom_range(1)) : 8'($urandom_range(255));
      end
      issue_beat(op, pid, va, val, 1'b0, '{ST_OK, 6'd0, 8'd0, 2'd0});
      if (op != OP_NONE)
        beats++;
      if ($urandom_range(99) < idle_pct[phase % 4]) begin
        @(negedge clk);
        start <= 1'b0;
        repeat ($urandom_range(29)) @(negedge clk);
      end
    end

    drain_replies();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/pmm_pkg.sv
design/pmm_datapath.sv
design/pmm_ctrl.sv
design/paged_memory_map_store_load_unit.sv
tb/tb_top.sv
